[rtl/core/homogeneous_point_transform_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the homogeneous point transform
// Concurrent assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH

// cond must never hold at a clock edge outside reset
`define HPT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// ante at a clock edge implies cons at the same edge
`define HPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/hpt_pkg.sv]
// ----------------------------------------------------------------------------
// hpt_pkg
// Widths, constants, types and helpers of the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;

    // matrix register file
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);
    localparam int CFG_W     = 2 * COORD_W;

    // datapath widths
    localparam int PROD_W = 2 * COORD_W;           // one entry times one coordinate
    localparam int SUM_W  = PROD_W + 2;            // three products, exact
    localparam int COL_W  = SUM_W - FRAC_BITS + 1; // rescaled sum plus row-3 term
    localparam int NUM_W  = COL_W + FRAC_BITS;     // |v| scaled up for the divide
    localparam int HI_W   = NUM_W - COORD_W;       // dividend bits above the quotient

    // lanes and pipeline depth
    localparam int NUM_LANES = 3;
    localparam int NUM_COLS  = 4;
    localparam int DIV_STEPS = COORD_W;
    localparam int COL_LAT   = 3;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int VLD_LEN   = COL_LAT + 1 + DIV_LAT;
    localparam int PIPE_LAT  = VLD_LEN + 1;

    // saturation limits
    localparam logic signed [COORD_W-1:0] S32_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] S32_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COL_W-1:0]   COL_MAX = COL_W'(S32_MAX);
    localparam logic signed [COL_W-1:0]   COL_MIN = COL_W'(S32_MIN);
    localparam logic signed [COL_W-1:0]   COL_ONE = COL_W'(1) << FRAC_BITS;

    // identity matrix after reset
    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << COORD_W;
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        ONE_LO, CFG_W'(0), ONE_HI, CFG_W'(0),
        CFG_W'(0), ONE_LO, CFG_W'(0), ONE_HI
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
        logic signed [COORD_W-1:0] z_in;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic signed [COORD_W-1:0] z_out;
        logic                      w_zero;
        logic                      saturated;
    } t_result;

    typedef struct packed {
        logic                      sat;
        logic signed [COORD_W-1:0] val;
    } t_sat32;

    // one coordinate as a divider lane delivers it
    typedef struct packed {
        logic signed [COORD_W-1:0] coord;
        logic                      sat;
    } t_lane_res;

    // clamp a column value to signed 32 bits
    function automatic t_sat32 sat32(input logic signed [COL_W-1:0] v);
        t_sat32 s;
        if (v > COL_MAX) begin
            s.val = S32_MAX;
            s.sat = 1'b1;
        end else if (v < COL_MIN) begin
            s.val = S32_MIN;
            s.sat = 1'b1;
        end else begin
            s.val = COORD_W'(v);
            s.sat = 1'b0;
        end
        return s;
    endfunction

    // register holding matrix entry (row, col): two columns per register
    function automatic logic [CFG_IDX_W-1:0] reg_index(input int row, input int col);
        return CFG_IDX_W'(2 * row + col / 2);
    endfunction

endpackage

[rtl/core/hpt_col_lane.sv]
// ----------------------------------------------------------------------------
// hpt_col_lane
// One matrix column: three products, exact sum, floor rescale, row-3 term.
// ----------------------------------------------------------------------------
module hpt_col_lane import hpt_pkg::*; (
    input  logic                      i_clk,
    input  t_point                    i_point,
    input  logic signed [COORD_W-1:0] i_m0,
    input  logic signed [COORD_W-1:0] i_m1,
    input  logic signed [COORD_W-1:0] i_m2,
    input  logic signed [COORD_W-1:0] i_m3,
    output logic signed [COL_W-1:0]   o_col
);

    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [COL_W-1:0]  r_col;

    // stage 1: one 32x32 multiplier per row
    always_ff @(posedge i_clk) begin
        r_p0 <= i_point.x_in * i_m0;
        r_p1 <= i_point.y_in * i_m1;
        r_p2 <= i_point.z_in * i_m2;
    end

    // stage 2: exact sum of the products
    always_ff @(posedge i_clk) begin
        r_sum <= SUM_W'(r_p0) + SUM_W'(r_p1) + SUM_W'(r_p2);
    end

    // stage 3: back to FRAC_BITS (floor), then the translation term
    always_ff @(posedge i_clk) begin
        r_col <= COL_W'(r_sum >>> FRAC_BITS) + COL_W'(i_m3);
    end

    assign o_col = r_col;

endmodule

[rtl/core/hpt_div_lane.sv]
// ----------------------------------------------------------------------------
// hpt_div_lane
// One coordinate: v * 2^F / w, truncated, saturated; pipelined restoring
// divider with one quotient bit per stage, or plain clamp in bypass.
// ----------------------------------------------------------------------------
module hpt_div_lane import hpt_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [COL_W-1:0]   i_v,
    input  logic signed [COORD_W-1:0] i_wd,
    input  logic                      i_byp,
    output t_lane_res                 o_res
);

    logic [COL_W-1:0]   mag_v;
    logic [COORD_W-1:0] mag_d;
    logic [NUM_W-1:0]   num;
    logic [HI_W-1:0]    num_hi;
    t_sat32             byp_sat;

    // per stage: partial remainder, dividend bits / quotient, divisor, flags
    logic [COORD_W-1:0] r_rem  [DIV_STEPS+1];
    logic [COORD_W-1:0] r_low  [DIV_STEPS+1];
    logic [COORD_W-1:0] r_d    [DIV_STEPS+1];
    logic               r_neg  [DIV_STEPS+1];
    logic               r_flag [DIV_STEPS+1];
    logic               r_byp  [DIV_STEPS+1];
    logic [COORD_W-1:0] n_rem  [DIV_STEPS+1];
    logic [COORD_W-1:0] n_low  [DIV_STEPS+1];
    logic               n_flag0;
    logic [COORD_W:0]   trial  [DIV_STEPS+1];
    logic               ge     [DIV_STEPS+1];

    t_lane_res          n_res;
    t_lane_res          r_res;
    logic [COORD_W-1:0] q;

    // entry: magnitudes, scaled dividend, quotient overflow check;
    // then the restoring steps, one per stage, bypass items pass unchanged
    always_comb begin
        mag_v   = i_v[COL_W-1] ? (~i_v + COL_W'(1)) : i_v;
        mag_d   = i_wd[COORD_W-1] ? (~i_wd + COORD_W'(1)) : i_wd;
        num     = {mag_v, FRAC_BITS'(0)};
        num_hi  = num[NUM_W-1:COORD_W];
        byp_sat = sat32(i_v);
        if (i_byp) begin
            n_rem[0] = '0;
            n_low[0] = byp_sat.val;
            n_flag0  = byp_sat.sat;
        end else begin
            n_rem[0] = num_hi[COORD_W-1:0];
            n_low[0] = num[COORD_W-1:0];
            n_flag0  = (num_hi >= HI_W'(mag_d));
        end
        trial[0] = '0;
        ge[0]    = 1'b0;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            trial[k] = {r_rem[k-1], r_low[k-1][COORD_W-1]};
            ge[k]    = (trial[k] >= {1'b0, r_d[k-1]});
            if (r_byp[k-1]) begin
                n_rem[k] = r_rem[k-1];
                n_low[k] = r_low[k-1];
            end else begin
                n_rem[k] = ge[k] ? COORD_W'(trial[k] - {1'b0, r_d[k-1]})
                                 : trial[k][COORD_W-1:0];
                n_low[k] = {r_low[k-1][COORD_W-2:0], ge[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_rem[0];
        r_low[0]  <= n_low[0];
        r_d[0]    <= mag_d;
        r_neg[0]  <= i_v[COL_W-1] ^ i_wd[COORD_W-1];
        r_flag[0] <= n_flag0;
        r_byp[0]  <= i_byp;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            r_rem[k]  <= n_rem[k];
            r_low[k]  <= n_low[k];
            r_d[k]    <= r_d[k-1];
            r_neg[k]  <= r_neg[k-1];
            r_flag[k] <= r_flag[k-1];
            r_byp[k]  <= r_byp[k-1];
        end
    end

    // sign and saturation of the quotient
    assign q = r_low[DIV_STEPS];

    always_comb begin
        if (r_byp[DIV_STEPS]) begin
            n_res.coord = q;
            n_res.sat   = r_flag[DIV_STEPS];
        end else if (r_flag[DIV_STEPS]) begin
            // quotient at or past 2^32
            n_res.coord = r_neg[DIV_STEPS] ? S32_MIN : S32_MAX;
            n_res.sat   = 1'b1;
        end else if (!r_neg[DIV_STEPS]) begin
            n_res.coord = q[COORD_W-1] ? S32_MAX : q;
            n_res.sat   = q[COORD_W-1];
        end else if (q[COORD_W-1] && (|q[COORD_W-2:0])) begin
            n_res.coord = S32_MIN;
            n_res.sat   = 1'b1;
        end else begin
            n_res.coord = ~q + COORD_W'(1);
            n_res.sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

[rtl/core/hpt_merge.sv]
// ----------------------------------------------------------------------------
// hpt_merge
// Combines the three coordinate lanes into one result item and registers it.
// ----------------------------------------------------------------------------
module hpt_merge import hpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_wz,
    input  t_lane_res i_res [NUM_LANES],
    output logic      o_valid,
    output t_result   o_result
);

    logic    r_valid;
    t_result r_result;

    // strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload: any clipped coordinate flags the item
    always_ff @(posedge i_clk) begin
        r_result.x_out     <= i_res[0].coord;
        r_result.y_out     <= i_res[1].coord;
        r_result.z_out     <= i_res[2].coord;
        r_result.w_zero    <= i_wz;
        r_result.saturated <= i_res[0].sat | i_res[1].sat | i_res[2].sat;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/core/homogeneous_point_transform.sv]
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// Q16.16 point times 4x4 matrix (implied w = 1) with perspective divide.
// ----------------------------------------------------------------------------
// Takes one item in every clock cycle: busy stays low and an item is accepted
// whenever start is high. The result of an accepted item is on o_result, with
// o_valid high, for one cycle only, since the receiver cannot hold results
// off. An item passes three column stages (multiply, sum, rescale), one stage
// that tests and clamps w, the 32-stage restoring divider in each coordinate
// lane with its entry and sign stages, and the output register. The user must
// write matrix registers only while no item is in flight; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module homogeneous_point_transform import hpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_point               i_point,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output t_result              o_result
);

    logic [CFG_W-1:0]          r_cfg [NUM_REGS];
    logic signed [COORD_W-1:0] mat   [NUM_COLS][NUM_COLS];
    logic                      accept;
    logic                      r_vld [VLD_LEN];

    logic signed [COL_W-1:0]   col   [NUM_COLS];
    t_sat32                    w_sat;
    logic                      w_is_zero;
    logic signed [COL_W-1:0]   r_v   [NUM_LANES];
    logic signed [COORD_W-1:0] r_wd;
    logic                      r_byp;
    logic                      r_wz  [DIV_LAT+1];
    t_lane_res                 div_res [NUM_LANES];

    // matrix registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // matrix entries, row by column
    always_comb begin
        for (int r = 0; r < NUM_COLS; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                mat[r][c] = ((c % 2) != 0) ? r_cfg[reg_index(r, c)][CFG_W-1:COORD_W]
                                           : r_cfg[reg_index(r, c)][COORD_W-1:0];
            end
        end
    end

    // input handshake: never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // item valid through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VLD_LEN; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= accept;
            for (int k = 1; k < VLD_LEN; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // column lanes: X, Y, Z and W
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
        hpt_col_lane u_col (
            .i_clk   (i_clk),
            .i_point (i_point),
            .i_m0    (mat[0][c]),
            .i_m1    (mat[1][c]),
            .i_m2    (mat[2][c]),
            .i_m3    (mat[3][c]),
            .o_col   (col[c])
        );
    end

    // w conditioning: zero and unit tests on the full value, divisor clamp
    assign w_sat     = sat32(col[NUM_COLS-1]);
    assign w_is_zero = (col[NUM_COLS-1] == COL_W'(0));

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_LANES; c++) begin
            r_v[c] <= col[c];
        end
        r_wd     <= w_sat.val;
        r_byp    <= w_is_zero || (col[NUM_COLS-1] == COL_ONE);
        r_wz[0]  <= w_is_zero;
        for (int k = 1; k <= DIV_LAT; k++) begin
            r_wz[k] <= r_wz[k-1];
        end
    end

    // divider lanes: X, Y, Z
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_div
        hpt_div_lane u_div (
            .i_clk (i_clk),
            .i_v   (r_v[l]),
            .i_wd  (r_wd),
            .i_byp (r_byp),
            .o_res (div_res[l])
        );
    end

    // merge and output register
    hpt_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[VLD_LEN-1]),
        .i_wz     (r_wz[DIV_LAT]),
        .i_res    (div_res),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

[rtl/core/hpt_checker.sv]
// ----------------------------------------------------------------------------
// hpt_checker
// Port-level checks of the point transform, bound to the top level.
// ----------------------------------------------------------------------------
`include "homogeneous_point_transform_defines.svh"

module hpt_checker import hpt_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_valid,
    input t_result o_result
);

    // the block takes an item in every cycle
    `HPT_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy, "block held off an item")

    // every result strobe belongs to an item accepted earlier
    `HPT_ASSERT_IMPLY(a_result_has_item, i_clk, i_rst_n, o_valid, $past(start && !busy, PIPE_LAT), "result strobe without a matching item")

    // a saturated item carries at least one clipped coordinate
    `HPT_ASSERT_IMPLY(a_sat_clips, i_clk, i_rst_n, o_valid && o_result.saturated, (o_result.x_out == S32_MAX) || (o_result.x_out == S32_MIN) || (o_result.y_out == S32_MAX) || (o_result.y_out == S32_MIN) || (o_result.z_out == S32_MAX) || (o_result.z_out == S32_MIN), "saturated flag without a clipped coordinate")

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);

[tb/sv/homogeneous_point_transform_tb.sv]
// ----------------------------------------------------------------------------
// homogeneous_point_transform_tb
// Self-checking bench: a Q16.16 predictor of the 4x4 transform and divide
// computes each result as a point is sent. Directed matrices cover the
// identity at reset, saturation, zero w, w of exactly one, tiny and negative
// w and a divisor beyond 32 bits. Random matrices and points follow, with
// random gaps on the send side.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_tb;
    import hpt_pkg::*;

    localparam int RESET_CYCLES    = 5;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int MAX_REPORTS     = 40;

    // Q16.16 values used as matrix entries and coordinates
    localparam longint ONE_FIX   = longint'(1) << FRAC_BITS;
    localparam longint QUOT_LIM  = longint'(1) << (COORD_W - FRAC_BITS);
    localparam longint COORD_MAX = longint'(S32_MAX);
    localparam longint COORD_MIN = longint'(S32_MIN);
    localparam logic [COORD_W-1:0] Q_ONE  = COORD_W'(ONE_FIX);
    localparam logic [COORD_W-1:0] Q_NONE = COORD_W'(-ONE_FIX);

    // kinds of random matrix
    typedef enum int {
        MAT_AFFINE,
        MAT_PERSPECTIVE,
        MAT_RANDOM,
        MAT_EXTREME
    } t_mat_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_point               i_point;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_valid;
    t_result              o_result;

    // predictor copy of the matrix, and the image staged for the next load
    logic [CFG_W-1:0] matrix_regs [NUM_REGS];
    logic [CFG_W-1:0] next_matrix [NUM_REGS];

    t_result pending_results [$];

    int error_count     = 0;
    int idle_cycles     = 0;
    int points_sent     = 0;
    int results_checked = 0;
    int wzero_results   = 0;
    int sat_results     = 0;
    int matrices_loaded = 0;

    homogeneous_point_transform i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_point   (i_point),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // matrix entry (row, col), sign-extended
    function automatic longint mat_entry(input int row, input int col);
        logic [CFG_W-1:0] r;
        r = matrix_regs[2 * row + col / 2];
        if (col % 2 == 1)
            return longint'($signed(r[CFG_W-1:COORD_W]));
        return longint'($signed(r[COORD_W-1:0]));
    endfunction

    // exact dot product, floored back to Q16.16, plus the row-3 term
    function automatic longint column_sum(input t_point p, input int col);
        logic signed [127:0] acc;
        acc = $signed(p.x_in) * mat_entry(0, col)
            + $signed(p.y_in) * mat_entry(1, col)
            + $signed(p.z_in) * mat_entry(2, col);
        return longint'(acc >>> FRAC_BITS) + mat_entry(3, col);
    endfunction

    function automatic longint clip32(input longint v, output bit clipped);
        clipped = 1'b0;
        if (v > COORD_MAX) begin
            clipped = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            clipped = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    // trunc(v * 2^F / w), saturated; w nonzero and within 32 bits
    function automatic longint divide_q16(input longint v, input longint w,
                                          output bit clipped);
        longint q;
        longint r;
        q = v / w;
        r = v % w;
        clipped = 1'b0;
        if (q > QUOT_LIM || q < -QUOT_LIM) begin
            clipped = 1'b1;
            return ((v < 0) != (w < 0)) ? COORD_MIN : COORD_MAX;
        end
        return clip32(q * ONE_FIX + (r * ONE_FIX) / w, clipped);
    endfunction

    function automatic t_result transform_point(input t_point p);
        t_result res;
        longint  v [3];
        longint  w;
        longint  wd;
        bit      clipped;
        bit      any_clip;
        for (int c = 0; c < 3; c++)
            v[c] = column_sum(p, c);
        w = column_sum(p, 3);
        any_clip = 1'b0;
        if (w == 0 || w == ONE_FIX) begin
            // no divide: clamp only
            for (int c = 0; c < 3; c++) begin
                v[c] = clip32(v[c], clipped);
                any_clip |= clipped;
            end
        end else begin
            // divisor clamp does not count as saturation
            wd = (w > COORD_MAX) ? COORD_MAX : ((w < COORD_MIN) ? COORD_MIN : w);
            for (int c = 0; c < 3; c++) begin
                v[c] = divide_q16(v[c], wd, clipped);
                any_clip |= clipped;
            end
        end
        res.x_out     = v[0][COORD_W-1:0];
        res.y_out     = v[1][COORD_W-1:0];
        res.z_out     = v[2][COORD_W-1:0];
        res.w_zero    = (w == 0);
        res.saturated = any_clip;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
                                   input logic [COORD_W-1:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch %s: got %h, want %h (result %0d)",
                     what, got, want, results_checked);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_result.x_out, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.x_out !== want.x_out)
                    report_mismatch("x_out", o_result.x_out, want.x_out);
                if (o_result.y_out !== want.y_out)
                    report_mismatch("y_out", o_result.y_out, want.y_out);
                if (o_result.z_out !== want.z_out)
                    report_mismatch("z_out", o_result.z_out, want.z_out);
                if (o_result.w_zero !== want.w_zero)
                    report_mismatch("w_zero", o_result.w_zero, want.w_zero);
                if (o_result.saturated !== want.saturated)
                    report_mismatch("saturated", o_result.saturated, want.saturated);
                results_checked++;
                wzero_results += want.w_zero;
                sat_results   += want.saturated;
            end
        end
    end

    // watchdog: cycles with no item taken and no result seen
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // idle for gap cycles, then hold the item until it is taken
    task automatic send_point(input t_point pt, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_point <= pt;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(transform_point(pt));
        points_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // write the staged image to all eight registers, pipeline empty
    task automatic load_matrix();
        wait_results_drained();
        for (int i = 0; i < NUM_REGS; i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= next_matrix[i];
            @(posedge i_clk);
            matrix_regs[i] = next_matrix[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        matrices_loaded++;
    endtask

    function automatic void stage_entry(input int row, input int col,
                                        input logic [COORD_W-1:0] val);
        next_matrix[2 * row + col / 2][(col % 2) * COORD_W +: COORD_W] = val;
    endfunction

    function automatic void stage_fill(input logic [COORD_W-1:0] val);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                stage_entry(r, c, val);
    endfunction

    function automatic t_point make_point(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [COORD_W-1:0] z);
        t_point p;
        p.x_in = x;
        p.y_in = y;
        p.z_in = z;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_W-1:0] small_coef();
        return COORD_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    function automatic logic [COORD_W-1:0] small_coord();
        return COORD_W'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
    endfunction

    function automatic logic [COORD_W-1:0] extreme_value();
        case ($urandom_range(0, 6))
            0: return S32_MIN;
            1: return S32_MAX;
            2: return '0;
            3: return Q_ONE;
            4: return Q_NONE;
            5: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void stage_random_matrix(input t_mat_style style);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                case (style)
                    MAT_AFFINE, MAT_PERSPECTIVE: begin
                        if (c < 3)
                            stage_entry(r, c, (r < 3) ? small_coef() : small_coord());
                        else if (style == MAT_AFFINE)
                            stage_entry(r, c, (r == 3) ? Q_ONE : '0);
                        else if (r == 2)
                            stage_entry(r, c, Q_ONE);
                        else
                            stage_entry(r, c, (r == 3) ? small_coef() : '0);
                    end
                    MAT_RANDOM: stage_entry(r, c, $urandom);
                    default:    stage_entry(r, c, extreme_value());
                endcase
            end
        end
    endfunction

    // w_follows_z: matrix has w = z + m33, so z can hit w zero or w one
    function automatic t_point random_point(input bit w_follows_z);
        int     roll;
        longint m33;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return make_point(small_coord(), small_coord(), small_coord());
        if (roll < 75)
            return make_point($urandom, $urandom, $urandom);
        if (roll < 88 || !w_follows_z)
            return make_point(extreme_value(), extreme_value(), extreme_value());
        m33 = mat_entry(3, 3);
        return make_point(small_coord(), small_coord(),
                          $urandom_range(0, 1) ? COORD_W'(ONE_FIX - m33) : COORD_W'(-m33));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // identity from reset: outputs equal inputs, no divide
    task automatic test_identity_extremes();
        send_point(make_point('0, '0, '0), 0);
        send_point(make_point(S32_MAX, S32_MIN, Q_ONE), 0);
        send_point(make_point(S32_MIN, S32_MAX, '1), 0);
        send_point(make_point(Q_ONE, Q_NONE, 32'h7FFF_0000), 0);
    endtask

    // scale by 2 with translation and w of one: overflow clamps
    task automatic test_scale_saturation();
        stage_fill('0);
        for (int d = 0; d < 3; d++)
            stage_entry(d, d, Q_ONE << 1);
        stage_entry(3, 0, COORD_W'(-3 * ONE_FIX));
        stage_entry(3, 1, Q_ONE >> 1);
        stage_entry(3, 2, COORD_W'(7 * ONE_FIX));
        stage_entry(3, 3, Q_ONE);
        load_matrix();
        send_point(make_point(S32_MAX, S32_MIN, 32'h4000_0000), 0);
        send_point(make_point(Q_ONE, Q_ONE << 1, COORD_W'(3 * ONE_FIX)), 0);
        send_point(make_point('1, '1, '1), 0);
    endtask

    // w = z: zero, one, tiny, negative and large divisors
    task automatic test_perspective_divide();
        stage_fill('0);
        for (int d = 0; d < 3; d++)
            stage_entry(d, d, Q_ONE);
        stage_entry(2, 3, Q_ONE);
        stage_entry(3, 0, Q_ONE >> 1);
        load_matrix();
        send_point(make_point(COORD_W'(3 * ONE_FIX), COORD_W'(-5 * ONE_FIX), '0), 0);
        send_point(make_point(S32_MAX, S32_MIN, '0), 1);
        send_point(make_point(COORD_W'(3 * ONE_FIX), COORD_W'(-5 * ONE_FIX), Q_ONE << 1), 0);
        send_point(make_point(Q_ONE, Q_ONE, COORD_W'(-ONE_FIX / 2)), 2);
        send_point(make_point(Q_ONE, Q_NONE, 32'd1), 0);
        send_point(make_point(32'd5, 32'd7, Q_ONE), 0);
        send_point(make_point(S32_MAX, S32_MIN, S32_MAX), 0);
        send_point(make_point(S32_MIN, S32_MIN, S32_MIN), 0);
    endtask

    // every entry at an extreme: w far beyond 32 bits, divisor clamped
    task automatic test_extreme_matrix();
        stage_fill(S32_MIN);
        load_matrix();
        send_point(make_point(S32_MIN, S32_MIN, S32_MIN), 0);
        send_point(make_point(S32_MAX, S32_MAX, S32_MAX), 0);
        send_point(make_point(S32_MAX, S32_MIN, '0), 0);
        stage_fill(S32_MAX);
        load_matrix();
        send_point(make_point(S32_MAX, S32_MAX, S32_MAX), 0);
        send_point(make_point(S32_MIN, '0, S32_MAX), 3);
    endtask

    // all-zero matrix: w zero, outputs zero
    task automatic test_zero_w_matrix();
        stage_fill('0);
        load_matrix();
        send_point(make_point(Q_ONE, S32_MAX, S32_MIN), 0);
        send_point(make_point('0, '0, '0), 0);
    endtask

    task automatic test_random_transforms();
        t_mat_style style;
        bit         back_to_back;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            style = t_mat_style'(phase % 4);
            stage_random_matrix(style);
            load_matrix();
            back_to_back = (phase % 3 == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // now and then let the pipeline empty before the next item
                if ($urandom_range(0, 59) == 0)
                    wait_results_drained();
                send_point(random_point(style == MAT_PERSPECTIVE),
                           back_to_back ? 0 : pick_gap());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_point    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        // identity after reset
        stage_fill('0);
        for (int d = 0; d < 4; d++)
            stage_entry(d, d, Q_ONE);
        for (int i = 0; i < NUM_REGS; i++)
            matrix_regs[i] = next_matrix[i];

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_identity_extremes();
        test_scale_saturation();
        test_perspective_divide();
        test_extreme_matrix();
        test_zero_w_matrix();
        test_random_transforms();

        // let the tail of the pipeline out, then look for strays
        wait_results_drained();
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", COORD_W'(pending_results.size()), '0);

        $display("Sent %0d points through %0d matrix loads plus reset identity; %0d results checked.",
                 points_sent, matrices_loaded, results_checked);
        $display("Results with w zero: %0d, with saturation: %0d; mismatches: %0d.",
                 wzero_results, sat_results, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
